FILE: src/cvg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvg_pkg
// Shared types and constants of the cowbell voice generator.
// ----------------------------------------------------------------------------
package cvg_pkg;

  // input field widths and tdata layout
  localparam int STEP_W       = 28;
  localparam int GAIN_W       = 16;
  localparam int FB1_W        = 18;
  localparam int FB2_W        = 17;
  localparam int IN_DATA_W    = 112;
  localparam int STEP_LOW_LSB = 0;
  localparam int STEP_HI_LSB  = STEP_LOW_LSB + STEP_W;
  localparam int GAIN_LSB     = STEP_HI_LSB + STEP_W;
  localparam int FB1_LSB      = GAIN_LSB + GAIN_W;
  localparam int FB2_LSB      = FB1_LSB + FB1_W;

  // phase steps are given in turns times 2^32
  localparam int STEP_FULL_W  = 32;

  // configuration registers
  localparam int DECAY_W      = 24;
  localparam int LEN_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_DECAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 1'd1;
  localparam logic [DECAY_W-1:0]   DECAY_RESET   = 24'd16770228;
  localparam logic [LEN_W-1:0]     LEN_RESET     = 16'd7200;

  // item kinds
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  // arithmetic
  localparam int COEF_FRAC = 16;
  localparam int MIX_FRAC  = 16;
  localparam int MIX_DRY   = 39322;
  localparam int MIX_WET   = 26214;
  localparam int MUL_B_W   = 25;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
  localparam logic [OP_W-1:0] OP_TRIGGER     = 4'd1;
  localparam logic [OP_W-1:0] OP_MAG         = 4'd2;
  localparam logic [OP_W-1:0] OP_RAW         = 4'd3;
  localparam logic [OP_W-1:0] OP_GAIN        = 4'd4;
  localparam logic [OP_W-1:0] OP_FB1         = 4'd5;
  localparam logic [OP_W-1:0] OP_FB2         = 4'd6;
  localparam logic [OP_W-1:0] OP_Y           = 4'd7;
  localparam logic [OP_W-1:0] OP_WET         = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT        = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT_SILENT = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic silent;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: src/cvg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvg_ctrl
// Sequencer: takes items and steps the datapath through one sample.
// ----------------------------------------------------------------------------
module cvg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic               in_cmd,
  input  wire cvg_pkg::dp_status_t status_i,
  output cvg_pkg::dp_cmd_t        cmd_o
);

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_MAG         = 4'd1;
  localparam logic [3:0] ST_RAW         = 4'd2;
  localparam logic [3:0] ST_GAIN        = 4'd3;
  localparam logic [3:0] ST_FB1         = 4'd4;
  localparam logic [3:0] ST_FB2         = 4'd5;
  localparam logic [3:0] ST_Y           = 4'd6;
  localparam logic [3:0] ST_WET         = 4'd7;
  localparam logic [3:0] ST_EMIT        = 4'd8;
  localparam logic [3:0] ST_EMIT_SILENT = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd_o.op   = cvg_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == cvg_pkg::CMD_TRIGGER) begin
            cmd_o.op = cvg_pkg::OP_TRIGGER;
          end else if (status_i.silent) begin
            state_nxt = ST_EMIT_SILENT;
          end else begin
            state_nxt = ST_MAG;
          end
        end
      end
      ST_MAG: begin
        cmd_o.op  = cvg_pkg::OP_MAG;
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        cmd_o.op  = cvg_pkg::OP_RAW;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.op  = cvg_pkg::OP_GAIN;
        state_nxt = ST_FB1;
      end
      ST_FB1: begin
        cmd_o.op  = cvg_pkg::OP_FB1;
        state_nxt = ST_FB2;
      end
      ST_FB2: begin
        cmd_o.op  = cvg_pkg::OP_FB2;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        cmd_o.op  = cvg_pkg::OP_Y;
        state_nxt = ST_WET;
      end
      ST_WET: begin
        cmd_o.op  = cvg_pkg::OP_WET;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op = cvg_pkg::OP_EMIT;
        if (status_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_SILENT: begin
        cmd_o.op = cvg_pkg::OP_EMIT_SILENT;
        if (status_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/cvg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvg_datapath
// Voice state, one shared multiplier, accumulator and the output register.
// ----------------------------------------------------------------------------
module cvg_datapath #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int ENV_BITS    = 24,
  parameter int OUT_DATA_W  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cvg_pkg::dp_cmd_t               cmd_i,
  output cvg_pkg::dp_status_t                 status_o,
  input  wire logic [cvg_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [cvg_pkg::DECAY_W-1:0]    decay_i,
  input  wire logic [cvg_pkg::LEN_W-1:0]      length_i,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [OUT_DATA_W-1:0]               out_tdata,
  output logic                                out_tuser
);

  localparam int HIST_W   = SAMPLE_BITS + 2;
  localparam int DATA_MAX = (ENV_BITS > HIST_W) ? ENV_BITS : HIST_W;
  localparam int A_W      = DATA_MAX + 1;
  localparam int P_W      = A_W + cvg_pkg::MUL_B_W;
  localparam int ACC_W    = P_W + 2;
  localparam longint AMP_SUM_L = ((64'd44 << (SAMPLE_BITS - 1)) + 64'd50) / 64'd100;
  localparam logic signed [cvg_pkg::MUL_B_W-1:0] AMP_SUM = cvg_pkg::MUL_B_W'(AMP_SUM_L);
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(longint'(1) << (cvg_pkg::COEF_FRAC - 1));

  // voice state
  logic [PHASE_BITS-1:0]              phase_a_r, phase_b_r;
  logic [ENV_BITS-1:0]                env_r;
  logic [cvg_pkg::LEN_W-1:0]          count_r;
  logic                               playing_r;
  logic [cvg_pkg::STEP_W-1:0]         held_step_a_r, held_step_b_r;
  logic [cvg_pkg::GAIN_W-1:0]         held_gain_r;
  logic signed [cvg_pkg::FB1_W-1:0]   held_fb1_r;
  logic signed [cvg_pkg::FB2_W-1:0]   held_fb2_r;
  logic signed [SAMPLE_BITS-1:0]      ih1_r, ih2_r;
  logic signed [HIST_W-1:0]           oh1_r, oh2_r;

  // working registers of one sample
  logic signed [SAMPLE_BITS-1:0]      raw_r;
  logic signed [HIST_W-1:0]           y_r;
  logic signed [P_W-1:0]              prod_r;
  logic signed [ACC_W-1:0]            acc_r;

  // output register
  logic                               out_valid_r;
  logic [SAMPLE_BITS-1:0]             out_sample_r;
  logic                               out_sounding_r;

  logic signed [A_W-1:0]              mul_a;
  logic signed [cvg_pkg::MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]              mul_p;
  logic signed [SAMPLE_BITS:0]        diff;
  logic signed [SAMPLE_BITS-1:0]      mag;
  logic signed [SAMPLE_BITS-1:0]      raw_calc;
  logic                               sign_a, sign_b;
  logic signed [ACC_W-1:0]            y_sum, y_sh, o_sum, o_sh;
  logic [ACC_W-HIST_W:0]              y_top;
  logic [ACC_W-SAMPLE_BITS:0]         o_top;
  logic signed [HIST_W-1:0]           y_sat;
  logic signed [SAMPLE_BITS-1:0]      o_sat;
  logic [cvg_pkg::STEP_FULL_W-1:0]    step_a_ext, step_b_ext;
  logic                               out_free;
  logic                               emit_go;

  assign out_free = !out_valid_r || out_tready;
  assign emit_go  = out_free && ((cmd_i.op == cvg_pkg::OP_EMIT) ||
                                 (cmd_i.op == cvg_pkg::OP_EMIT_SILENT));

  assign status_o.out_free = out_free;
  assign status_o.silent   = !playing_r || (count_r >= length_i);

  // operand selection for the shared multiplier
  assign diff = (SAMPLE_BITS + 1)'(raw_r) - (SAMPLE_BITS + 1)'(ih2_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      cvg_pkg::OP_MAG: begin
        mul_a = A_W'($signed({1'b0, env_r}));
        mul_b = AMP_SUM;
      end
      cvg_pkg::OP_RAW: begin
        mul_a = A_W'($signed({1'b0, env_r}));
        mul_b = cvg_pkg::MUL_B_W'($signed({1'b0, decay_i}));
      end
      cvg_pkg::OP_GAIN: begin
        mul_a = A_W'(diff);
        mul_b = cvg_pkg::MUL_B_W'($signed({1'b0, held_gain_r}));
      end
      cvg_pkg::OP_FB1: begin
        mul_a = A_W'(oh1_r);
        mul_b = cvg_pkg::MUL_B_W'(held_fb1_r);
      end
      cvg_pkg::OP_FB2: begin
        mul_a = A_W'(oh2_r);
        mul_b = cvg_pkg::MUL_B_W'(held_fb2_r);
      end
      cvg_pkg::OP_Y: begin
        mul_a = A_W'(raw_r);
        mul_b = cvg_pkg::MUL_B_W'(cvg_pkg::MIX_DRY);
      end
      cvg_pkg::OP_WET: begin
        mul_a = A_W'(y_r);
        mul_b = cvg_pkg::MUL_B_W'(cvg_pkg::MIX_WET);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // square sum times envelope: product is never negative
  assign sign_a   = phase_a_r[PHASE_BITS-1];
  assign sign_b   = phase_b_r[PHASE_BITS-1];
  assign mag      = $signed(prod_r[ENV_BITS +: SAMPLE_BITS]);
  assign raw_calc = (sign_a != sign_b) ? '0 : (sign_a ? -mag : mag);

  // bandpass output, rounded and saturated
  assign y_sum = acc_r - ACC_W'(prod_r) + ROUND_HALF;
  assign y_sh  = y_sum >>> cvg_pkg::COEF_FRAC;
  assign y_top = y_sh[ACC_W-1:HIST_W-1];
  assign y_sat = ((&y_top) || !(|y_top)) ? y_sh[HIST_W-1:0]
               : {y_top[ACC_W-HIST_W], {(HIST_W - 1){~y_top[ACC_W-HIST_W]}}};

  // dry plus wet mix, rounded and saturated
  assign o_sum = acc_r + ACC_W'(prod_r) + ROUND_HALF;
  assign o_sh  = o_sum >>> cvg_pkg::MIX_FRAC;
  assign o_top = o_sh[ACC_W-1:SAMPLE_BITS-1];
  assign o_sat = ((&o_top) || !(|o_top)) ? o_sh[SAMPLE_BITS-1:0]
               : {o_top[ACC_W-SAMPLE_BITS], {(SAMPLE_BITS - 1){~o_top[ACC_W-SAMPLE_BITS]}}};

  assign step_a_ext = cvg_pkg::STEP_FULL_W'(held_step_a_r);
  assign step_b_ext = cvg_pkg::STEP_FULL_W'(held_step_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (cmd_i.op)
        cvg_pkg::OP_TRIGGER: begin
          held_step_a_r <= in_tdata[cvg_pkg::STEP_LOW_LSB +: cvg_pkg::STEP_W];
          held_step_b_r <= in_tdata[cvg_pkg::STEP_HI_LSB +: cvg_pkg::STEP_W];
          held_gain_r   <= in_tdata[cvg_pkg::GAIN_LSB +: cvg_pkg::GAIN_W];
          held_fb1_r    <= $signed(in_tdata[cvg_pkg::FB1_LSB +: cvg_pkg::FB1_W]);
          held_fb2_r    <= $signed(in_tdata[cvg_pkg::FB2_LSB +: cvg_pkg::FB2_W]);
          phase_a_r     <= '0;
          phase_b_r     <= '0;
          ih1_r         <= '0;
          ih2_r         <= '0;
          oh1_r         <= '0;
          oh2_r         <= '0;
          count_r       <= '0;
          env_r         <= '1;
          playing_r     <= 1'b1;
        end
        cvg_pkg::OP_MAG: begin
          prod_r <= mul_p;
        end
        cvg_pkg::OP_RAW: begin
          raw_r  <= raw_calc;
          prod_r <= mul_p;
        end
        cvg_pkg::OP_GAIN: begin
          // envelope decay product lands here
          env_r  <= prod_r[cvg_pkg::DECAY_W +: ENV_BITS];
          prod_r <= mul_p;
        end
        cvg_pkg::OP_FB1: begin
          acc_r  <= ACC_W'(prod_r);
          prod_r <= mul_p;
        end
        cvg_pkg::OP_FB2: begin
          acc_r  <= acc_r - ACC_W'(prod_r);
          prod_r <= mul_p;
        end
        cvg_pkg::OP_Y: begin
          y_r    <= y_sat;
          prod_r <= mul_p;
        end
        cvg_pkg::OP_WET: begin
          acc_r  <= ACC_W'(prod_r);
          prod_r <= mul_p;
        end
        cvg_pkg::OP_EMIT: begin
          if (emit_go) begin
            out_valid_r    <= 1'b1;
            out_sample_r   <= o_sat;
            out_sounding_r <= 1'b1;
            ih2_r          <= ih1_r;
            ih1_r          <= raw_r;
            oh2_r          <= oh1_r;
            oh1_r          <= y_r;
            phase_a_r      <= phase_a_r + step_a_ext[cvg_pkg::STEP_FULL_W-1 -: PHASE_BITS];
            phase_b_r      <= phase_b_r + step_b_ext[cvg_pkg::STEP_FULL_W-1 -: PHASE_BITS];
            count_r        <= count_r + 1'b1;
          end
        end
        cvg_pkg::OP_EMIT_SILENT: begin
          if (emit_go) begin
            out_valid_r    <= 1'b1;
            out_sample_r   <= '0;
            out_sounding_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_sample_r);
  assign out_tuser  = out_sounding_r;

endmodule
`default_nettype wire

FILE: src/cowbell_voice_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cowbell_voice_generator_top
// Cowbell voice: two square oscillators, decaying envelope, biquad bandpass.
// ----------------------------------------------------------------------------
// sounding tick: states MAG to WET, then EMIT; next item taken only after the result
// silent tick: result from EMIT_SILENT, next item taken only after it
// trigger: handled in the idle state, no result
// one shared multiplier runs seven products per sample and sets the rate
// rst_n (synchronous) idles the sequencer, silences the voice, loads register defaults
module cowbell_voice_generator_top #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int ENV_BITS    = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // config
  input  wire logic                            cfg_we,
  input  wire logic [cvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cvg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // step_low[27:0], step_high[55:28], bp_gain[71:56], bp_fb1[89:72], bp_fb2[106:90]
  input  wire logic [cvg_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[0]
  input  wire logic                            in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // sample[SAMPLE_BITS-1:0]
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  // sounding[0]
  output logic                                 out_tuser
);

  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [cvg_pkg::DECAY_W-1:0] decay_r;
  logic [cvg_pkg::LEN_W-1:0]   length_r;
  cvg_pkg::dp_cmd_t            dp_cmd;
  cvg_pkg::dp_status_t         dp_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= cvg_pkg::DECAY_RESET;
      length_r <= cvg_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cvg_pkg::CFG_ENV_DECAY: decay_r  <= cfg_wdata[cvg_pkg::DECAY_W-1:0];
        cvg_pkg::CFG_LENGTH:    length_r <= cfg_wdata[cvg_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cvg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd)
  );

  cvg_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENV_BITS    (ENV_BITS),
    .OUT_DATA_W  (OUT_DATA_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .in_tdata   (in_tdata),
    .decay_i    (decay_r),
    .length_i   (length_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
